[hdl/iteration_count_colormap_defines.svh]
// ----------------------------------------------------------------------------
// Iteration count colormap assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ITERATION_COUNT_COLORMAP_DEFINES_SVH
`define ITERATION_COUNT_COLORMAP_DEFINES_SVH

// cond holds at every clock edge out of reset
`define ICC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ICC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/icc_pkg.sv]
// ----------------------------------------------------------------------------
// Iteration count colormap package
// Shared types and constants for the colormap front end and division cells.
// ----------------------------------------------------------------------------
package icc_pkg;

    // quotient bits produced by the division chain, one per cell
    localparam int QUO_BITS = 25;

    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_MODE    = 4'd1;

    localparam int MAX_ITER_RESET = 500;

    typedef struct packed {
        logic valid;
        logic smooth;
    } cell_ctrl_t;

endpackage

[hdl/icc_front.sv]
// ----------------------------------------------------------------------------
// Colormap front end
// Clamps the count, forms the products and loads the division numerators.
// ----------------------------------------------------------------------------
module icc_front
    import icc_pkg::*;
#(
    parameter int COUNT_BITS = 12
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [COUNT_BITS-1:0]                in_count,
    input  logic [COUNT_BITS-1:0]                max_iter,
    input  logic                                 smooth,
    output cell_ctrl_t                           ctrl_out,
    output logic [4*COUNT_BITS-1:0]              div_out,
    output logic [2:0][4*COUNT_BITS-1:0]         rem_out,
    output logic [2:0][QUO_BITS-1:0]             low_out
);

    localparam int DW = 4 * COUNT_BITS;
    localparam int PW = 2 * COUNT_BITS;
    localparam int NW = DW + QUO_BITS;

    logic [COUNT_BITS-1:0] m_lim;
    logic [COUNT_BITS-1:0] n_clamp;

    cell_ctrl_t            a_ctrl_reg;
    logic [COUNT_BITS-1:0] a_n_reg, a_k_reg, a_m_reg;

    cell_ctrl_t            b_ctrl_reg;
    logic [COUNT_BITS-1:0] b_n_reg, b_m_reg;
    logic [PW-1:0]         b_nn_reg, b_kk_reg, b_kn_reg, b_mm_reg;

    cell_ctrl_t            c_ctrl_reg;
    logic [COUNT_BITS-1:0] c_n_reg, c_m_reg;
    logic [DW-1:0]         c_pa_reg, c_pb_reg, c_pc_reg, c_pd_reg;

    cell_ctrl_t                 d_ctrl_reg;
    logic [DW-1:0]              d_div_reg, d_div_next;
    logic [2:0][DW-1:0]         d_rem_reg, d_rem_next;
    logic [2:0][QUO_BITS-1:0]   d_low_reg, d_low_next;

    logic [NW-1:0] num_r, num_g, num_b;

    // a zero limit acts as one; counts above the limit clamp to it
    assign m_lim   = (max_iter == '0) ? COUNT_BITS'(1) : max_iter;
    assign n_clamp = (in_count > m_lim) ? m_lim : in_count;

    // 1020 = 1024 - 4, 1530 = 1024 + 512 - 4 - 2
    assign num_r = (NW'(c_pa_reg) << 10) - (NW'(c_pa_reg) << 2);
    assign num_g = (NW'(c_pb_reg) << 10) + (NW'(c_pb_reg) << 9)
                 - (NW'(c_pb_reg) << 2) - (NW'(c_pb_reg) << 1);
    assign num_b = (NW'(c_pc_reg) << 10) - (NW'(c_pc_reg) << 2);

    always_comb
    begin
        if (c_ctrl_reg.smooth)
        begin
            d_div_next    = c_pd_reg;
            d_rem_next[0] = num_r[NW-1:QUO_BITS];
            d_rem_next[1] = num_g[NW-1:QUO_BITS];
            d_rem_next[2] = num_b[NW-1:QUO_BITS];
            d_low_next[0] = num_r[QUO_BITS-1:0];
            d_low_next[1] = num_g[QUO_BITS-1:0];
            d_low_next[2] = num_b[QUO_BITS-1:0];
        end
        else
        begin
            // numerator is n * 2^24
            d_div_next    = DW'(c_m_reg);
            d_rem_next[0] = DW'(c_n_reg >> 1);
            d_rem_next[1] = '0;
            d_rem_next[2] = '0;
            d_low_next[0] = {c_n_reg[0], {(QUO_BITS-1){1'b0}}};
            d_low_next[1] = '0;
            d_low_next[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
            d_ctrl_reg <= '0;
        end
        else if (en)
        begin
            a_ctrl_reg.valid  <= in_valid;
            a_ctrl_reg.smooth <= smooth;
            b_ctrl_reg        <= a_ctrl_reg;
            c_ctrl_reg        <= b_ctrl_reg;
            d_ctrl_reg        <= c_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n_reg   <= n_clamp;
            a_k_reg   <= m_lim - n_clamp;
            a_m_reg   <= m_lim;

            b_n_reg   <= a_n_reg;
            b_m_reg   <= a_m_reg;
            b_nn_reg  <= PW'(a_n_reg) * PW'(a_n_reg);
            b_kk_reg  <= PW'(a_k_reg) * PW'(a_k_reg);
            b_kn_reg  <= PW'(a_k_reg) * PW'(a_n_reg);
            b_mm_reg  <= PW'(a_m_reg) * PW'(a_m_reg);

            c_n_reg   <= b_n_reg;
            c_m_reg   <= b_m_reg;
            c_pa_reg  <= DW'(b_kn_reg) * DW'(b_nn_reg);
            c_pb_reg  <= DW'(b_kn_reg) * DW'(b_kn_reg);
            c_pc_reg  <= DW'(b_kn_reg) * DW'(b_kk_reg);
            c_pd_reg  <= DW'(b_mm_reg) * DW'(b_mm_reg);

            d_div_reg <= d_div_next;
            d_rem_reg <= d_rem_next;
            d_low_reg <= d_low_next;
        end
    end

    assign ctrl_out = d_ctrl_reg;
    assign div_out  = d_div_reg;
    assign rem_out  = d_rem_reg;
    assign low_out  = d_low_reg;

endmodule

[hdl/icc_div_cell.sv]
// ----------------------------------------------------------------------------
// Colormap division cell
// One restoring division step on three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module icc_div_cell
    import icc_pkg::*;
#(
    parameter int DW = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  cell_ctrl_t                   ctrl_in,
    input  logic [DW-1:0]                div_in,
    input  logic [2:0][DW-1:0]           rem_in,
    input  logic [2:0][QUO_BITS-1:0]     low_in,
    input  logic [2:0][QUO_BITS-1:0]     quo_in,
    output cell_ctrl_t                   ctrl_out,
    output logic [DW-1:0]                div_out,
    output logic [2:0][DW-1:0]           rem_out,
    output logic [2:0][QUO_BITS-1:0]     low_out,
    output logic [2:0][QUO_BITS-1:0]     quo_out
);

    cell_ctrl_t               ctrl_reg;
    logic [DW-1:0]            div_reg;
    logic [2:0][DW-1:0]       rem_reg, rem_next;
    logic [2:0][QUO_BITS-1:0] low_reg, low_next;
    logic [2:0][QUO_BITS-1:0] quo_reg, quo_next;
    logic [2:0][DW:0]         trial, diff;
    logic [2:0]               fits;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            // bring down the next numerator bit, subtract if it fits
            trial[j]    = {rem_in[j], low_in[j][QUO_BITS-1]};
            diff[j]     = trial[j] - {1'b0, div_in};
            fits[j]     = trial[j] >= {1'b0, div_in};
            rem_next[j] = fits[j] ? diff[j][DW-1:0] : trial[j][DW-1:0];
            low_next[j] = {low_in[j][QUO_BITS-2:0], 1'b0};
            quo_next[j] = {quo_in[j][QUO_BITS-2:0], fits[j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_in;
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign div_out  = div_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;
    assign quo_out  = quo_reg;

endmodule

[hdl/iteration_count_colormap.sv]
// Throughput: one count per cycle while the skid buffer is empty; the 4-stage product
// front end feeds a chain of 25 division cells, one quotient bit per cell.
// An output register with a one-entry skid buffer decouples m_tready from s_tready.
// Reset: max_iterations = 500, smooth_mode = 0, pipeline and outputs empty.
// ----------------------------------------------------------------------------
// Iteration count colormap
// Maps an escape-time count to RGB, piecewise byte split or Bernstein curves.
// ----------------------------------------------------------------------------
`include "iteration_count_colormap_defines.svh"

module iteration_count_colormap
    import icc_pkg::*;
#(
    parameter int COUNT_BITS = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // tdata: iteration_count
    input  logic [((COUNT_BITS+7)/8)*8-1:0]        s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: red [7:0], green [15:8], blue [23:16]
    output logic [23:0]                            m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [COUNT_BITS-1:0]                  cfg_data
);

    localparam int DW    = 4 * COUNT_BITS;
    localparam int CELLS = QUO_BITS;
    localparam logic [COUNT_BITS-1:0] MAX_RESET =
        COUNT_BITS'(MAX_ITER_RESET & ((1 << COUNT_BITS) - 1));

    logic [COUNT_BITS-1:0] max_iter_reg;
    logic                  smooth_reg;

    logic en;

    cell_ctrl_t               ctrl_c [CELLS+1];
    logic [DW-1:0]            div_c  [CELLS+1];
    logic [2:0][DW-1:0]       rem_c  [CELLS+1];
    logic [2:0][QUO_BITS-1:0] low_c  [CELLS+1];
    logic [2:0][QUO_BITS-1:0] quo_c  [CELLS+1];

    logic [23:0] last_data;
    logic        push, take;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [23:0] skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_RESET;
            smooth_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ITERATIONS: max_iter_reg <= cfg_data;
                REG_SMOOTH_MODE:    smooth_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // advance the whole pipeline while the skid buffer is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    icc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_count (s_tdata[COUNT_BITS-1:0]),
        .max_iter (max_iter_reg),
        .smooth   (smooth_reg),
        .ctrl_out (ctrl_c[0]),
        .div_out  (div_c[0]),
        .rem_out  (rem_c[0]),
        .low_out  (low_c[0])
    );

    assign quo_c[0] = '0;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        icc_div_cell #(
            .DW (DW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_c[i]),
            .div_in   (div_c[i]),
            .rem_in   (rem_c[i]),
            .low_in   (low_c[i]),
            .quo_in   (quo_c[i]),
            .ctrl_out (ctrl_c[i+1]),
            .div_out  (div_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .low_out  (low_c[i+1]),
            .quo_out  (quo_c[i+1])
        );
    end

    always_comb
    begin
        if (ctrl_c[CELLS].smooth)
        begin
            last_data = {quo_c[CELLS][2][7:0], quo_c[CELLS][1][7:0], quo_c[CELLS][0][7:0]};
        end
        else
        begin
            // blue = q[23:16], green = q[7:0], red = q[15:8]
            last_data = {quo_c[CELLS][0][23:16], quo_c[CELLS][0][7:0],
                         quo_c[CELLS][0][15:8]};
        end
    end

    assign push = en && ctrl_c[CELLS].valid;
    assign take = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = last_data;
            end
        end
        else if (push)
        begin
            // output held: park the transfer in the skid buffer
            skid_valid_next = 1'b1;
            skid_data_next  = last_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ICC_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid full, output empty")
    `ICC_ASSERT_NEXT(a_skid_fill, !out_valid_reg, !skid_valid_reg, "skid filled past empty output")
    `ICC_ASSERT_NEXT(a_stall_holds, !en, $stable(ctrl_c[CELLS].valid), "chain moved while stalled")
    `ICC_ASSERT_ALWAYS(a_rem_below_div, !ctrl_c[CELLS].valid || ((rem_c[CELLS][0] < div_c[CELLS]) && (rem_c[CELLS][1] < div_c[CELLS]) && (rem_c[CELLS][2] < div_c[CELLS])), "remainder not below divisor")

endmodule
